// ===== hw/rtl/mafh_pkg.sv =====
// shared types, tables and constants for the mpeg audio frame header decoder
`timescale 1ns / 1ps

package mafh_pkg;

   localparam int HDR_W     = 32;
   localparam int KBPS_W    = 9;
   localparam int RATE_W    = 16;
   localparam int FRAME_W   = 12;
   localparam int FACTOR_W  = 18;
   localparam int NUM_W     = 26;
   localparam int QUOT_W    = FRAME_W;
   localparam int REM_W     = RATE_W;
   localparam int DIV_CELLS = QUOT_W;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_BAD_VER    = 2'd1;
   localparam logic [1:0] STATUS_BAD_LAYER  = 2'd2;

   localparam logic [1:0] VCODE_MPEG1       = 2'b11;
   localparam logic [1:0] VCODE_MPEG2       = 2'b10;
   localparam logic [1:0] VCODE_RESERVED    = 2'b01;
   localparam logic [1:0] LCODE_RESERVED    = 2'b00;

   localparam logic [1:0] VER_MPEG1         = 2'd0;
   localparam logic [1:0] VER_MPEG2         = 2'd1;
   localparam logic [1:0] VER_MPEG25        = 2'd2;

   localparam logic [1:0] LAYER_1           = 2'd1;
   localparam logic [1:0] LAYER_3           = 2'd3;

   localparam logic [FACTOR_W-1:0] FACTOR_12  = 18'd12000;
   localparam logic [FACTOR_W-1:0] FACTOR_72  = 18'd72000;
   localparam logic [FACTOR_W-1:0] FACTOR_144 = 18'd144000;

   typedef enum logic [1:0] {
      COEF_12,
      COEF_72,
      COEF_144
   } coef_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [1:0]        version;
      logic [1:0]        layer;
      logic              crc;
      logic [KBPS_W-1:0] kbps;
      logic [RATE_W-1:0] rate;
      logic              pad;
      logic [1:0]        mode;
      logic              slot4;
      logic              zero;
      coef_type          coef;
   } info_type;

   typedef struct packed {
      info_type           info;
      logic [REM_W-1:0]   rem;
      logic [QUOT_W-1:0]  word;
   } div_type;

   localparam logic [KBPS_W-1:0] KBPS_TAB [5][16] = '{
      '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
        9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
      '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
      '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
        9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0},
      '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
      '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
        9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}
   };

   localparam logic [RATE_W-1:0] RATE_TAB [3][4] = '{
      '{16'd44100, 16'd48000, 16'd32000, 16'd0},
      '{16'd22050, 16'd24000, 16'd16000, 16'd0},
      '{16'd11025, 16'd12000, 16'd8000,  16'd0}
   };

   function automatic logic [KBPS_W-1:0] kbps_lookup(input logic [2:0] row,
                                                     input logic [3:0] idx);
      logic [KBPS_W-1:0] kbps;
      case (row)
         3'd0: kbps = KBPS_TAB[0][idx];
         3'd1: kbps = KBPS_TAB[1][idx];
         3'd2: kbps = KBPS_TAB[2][idx];
         3'd3: kbps = KBPS_TAB[3][idx];
         default: kbps = KBPS_TAB[4][idx];
      endcase
      return kbps;
   endfunction

   function automatic logic [RATE_W-1:0] rate_lookup(input logic [1:0] ver,
                                                     input logic [1:0] idx);
      logic [RATE_W-1:0] rate;
      case (ver)
         VER_MPEG1: rate = RATE_TAB[0][idx];
         VER_MPEG2: rate = RATE_TAB[1][idx];
         default:   rate = RATE_TAB[2][idx];
      endcase
      return rate;
   endfunction

endpackage

// ===== hw/rtl/mafh_decode.sv =====
// header field decode and table lookup stage
`timescale 1ns / 1ps

module mafh_decode (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic [mafh_pkg::HDR_W-1:0] in_header,
   output logic                     out_valid,
   input  logic                     out_ready,
   output mafh_pkg::info_type       out_info
);

   logic               valid_ff;
   logic               valid_in;
   mafh_pkg::info_type info_ff;
   mafh_pkg::info_type info_in;
   logic               load;

   logic [1:0] vcode;
   logic [1:0] lcode;
   logic [1:0] ver;
   logic [1:0] layer;
   logic [2:0] row;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;
   assign vcode    = in_header[20:19];
   assign lcode    = in_header[18:17];

   always_comb begin
      case (vcode)
         mafh_pkg::VCODE_MPEG1: ver = mafh_pkg::VER_MPEG1;
         mafh_pkg::VCODE_MPEG2: ver = mafh_pkg::VER_MPEG2;
         default:               ver = mafh_pkg::VER_MPEG25;
      endcase
      layer = 2'(3'd4 - {1'b0, lcode});
      if (ver == mafh_pkg::VER_MPEG1) begin
         row = 3'(layer - 2'd1);
      end else if (layer == mafh_pkg::LAYER_1) begin
         row = 3'd3;
      end else begin
         row = 3'd4;
      end
   end

   always_comb begin
      info_in = '0;
      if (vcode == mafh_pkg::VCODE_RESERVED) begin
         info_in.status = mafh_pkg::STATUS_BAD_VER;
         info_in.zero   = 1'b1;
      end else if (lcode == mafh_pkg::LCODE_RESERVED) begin
         info_in.status = mafh_pkg::STATUS_BAD_LAYER;
         info_in.zero   = 1'b1;
      end else begin
         info_in.status  = mafh_pkg::STATUS_OK;
         info_in.version = ver;
         info_in.layer   = layer;
         info_in.crc     = !in_header[16];
         info_in.kbps    = mafh_pkg::kbps_lookup(row, in_header[15:12]);
         info_in.rate    = mafh_pkg::rate_lookup(ver, in_header[11:10]);
         info_in.pad     = in_header[9];
         info_in.mode    = in_header[7:6];
         info_in.slot4   = (layer == mafh_pkg::LAYER_1);
         info_in.zero    = (info_in.kbps == '0) || (info_in.rate == '0);
         if (layer == mafh_pkg::LAYER_1) begin
            info_in.coef = mafh_pkg::COEF_12;
         end else if (layer == mafh_pkg::LAYER_3 && ver != mafh_pkg::VER_MPEG1) begin
            info_in.coef = mafh_pkg::COEF_72;
         end else begin
            info_in.coef = mafh_pkg::COEF_144;
         end
      end
   end

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         info_ff <= info_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_info  = info_ff;

endmodule

// ===== hw/rtl/mafh_scale.sv =====
// numerator stage: coef * kbps * 1000 split into divider start state
`timescale 1ns / 1ps

module mafh_scale (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  mafh_pkg::info_type in_info,
   output logic               out_valid,
   input  logic               out_ready,
   output mafh_pkg::div_type  out_data
);

   logic                            valid_ff;
   logic                            valid_in;
   mafh_pkg::div_type               data_ff;
   mafh_pkg::div_type               data_in;
   logic                            load;
   logic [mafh_pkg::FACTOR_W-1:0]   factor;
   logic [mafh_pkg::KBPS_W+mafh_pkg::FACTOR_W-1:0] prod;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   always_comb begin
      case (in_info.coef)
         mafh_pkg::COEF_12: factor = mafh_pkg::FACTOR_12;
         mafh_pkg::COEF_72: factor = mafh_pkg::FACTOR_72;
         default:           factor = mafh_pkg::FACTOR_144;
      endcase
   end

   assign prod = (mafh_pkg::KBPS_W + mafh_pkg::FACTOR_W)'(in_info.kbps) *
                 (mafh_pkg::KBPS_W + mafh_pkg::FACTOR_W)'(factor);

   always_comb begin
      data_in.info = in_info;
      data_in.rem  = mafh_pkg::REM_W'(prod[mafh_pkg::NUM_W-1:mafh_pkg::QUOT_W]);
      data_in.word = prod[mafh_pkg::QUOT_W-1:0];
   end

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== hw/rtl/mafh_div_cell.sv =====
// one restoring division step: one quotient bit per cell
`timescale 1ns / 1ps

module mafh_div_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  mafh_pkg::div_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output mafh_pkg::div_type out_data
);

   logic                       valid_ff;
   logic                       valid_in;
   mafh_pkg::div_type          data_ff;
   mafh_pkg::div_type          data_in;
   logic                       load;
   logic [mafh_pkg::REM_W:0]   trial;
   logic [mafh_pkg::REM_W:0]   diff;
   logic                       ge;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   assign trial = {in_data.rem, in_data.word[mafh_pkg::QUOT_W-1]};
   assign diff  = trial - {1'b0, in_data.info.rate};
   assign ge    = trial >= {1'b0, in_data.info.rate};

   always_comb begin
      data_in.info = in_data.info;
      data_in.rem  = ge ? diff[mafh_pkg::REM_W-1:0] : trial[mafh_pkg::REM_W-1:0];
      data_in.word = {in_data.word[mafh_pkg::QUOT_W-2:0], ge};
   end

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // partial remainder stays below the divisor for any usable item
   a_rem_below_rate: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !data_ff.info.zero |-> data_ff.rem < data_ff.info.rate)
      else $error("partial remainder not below divisor");

endmodule

// ===== hw/rtl/mpeg_audio_frame_header_decode_core.sv =====
// top level: mpeg audio frame header decoder with pipelined frame length divider
// pipeline: registered stages from item acceptance to result valid (decode, scale,
//   twelve divider cells, output register)
// throughput: one item per cycle unless stalled, one quotient bit per divider cell
// every stage has its own valid; an empty stage accepts while the stage after it stalls
// reset (synchronous) clears all stage valids; payload registers are not reset
`timescale 1ns / 1ps

module mpeg_audio_frame_header_decode_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [mafh_pkg::HDR_W-1:0]    req_header_word,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_status,
   output logic [1:0]                    rsp_audio_version,
   output logic [1:0]                    rsp_layer_number,
   output logic                          rsp_crc_protected,
   output logic [mafh_pkg::KBPS_W-1:0]   rsp_bitrate_kbps,
   output logic [mafh_pkg::RATE_W-1:0]   rsp_sample_rate_hz,
   output logic                          rsp_padding_on,
   output logic [1:0]                    rsp_channel_mode,
   output logic [mafh_pkg::FRAME_W-1:0]  rsp_frame_bytes
);

   logic               dec_valid;
   logic               dec_ready;
   mafh_pkg::info_type dec_info;

   logic              cell_valid [mafh_pkg::DIV_CELLS+1];
   logic              cell_ready [mafh_pkg::DIV_CELLS+1];
   mafh_pkg::div_type cell_data  [mafh_pkg::DIV_CELLS+1];

   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic                          load;
   mafh_pkg::info_type            fin_info;
   logic [mafh_pkg::FRAME_W-1:0]  sum;
   logic [mafh_pkg::FRAME_W-1:0]  frame_in;
   logic [1:0]                    status_ff;
   logic [1:0]                    version_ff;
   logic [1:0]                    layer_ff;
   logic                          crc_ff;
   logic [mafh_pkg::KBPS_W-1:0]   kbps_ff;
   logic [mafh_pkg::RATE_W-1:0]   rate_ff;
   logic                          pad_ff;
   logic [1:0]                    mode_ff;
   logic [mafh_pkg::FRAME_W-1:0]  frame_ff;

   mafh_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_header (req_header_word),
      .out_valid (dec_valid),
      .out_ready (dec_ready),
      .out_info  (dec_info)
   );

   mafh_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_ready  (dec_ready),
      .in_info   (dec_info),
      .out_valid (cell_valid[0]),
      .out_ready (cell_ready[0]),
      .out_data  (cell_data[0])
   );

   for (genvar gi = 0; gi < mafh_pkg::DIV_CELLS; gi++) begin : g_cell
      mafh_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (cell_valid[gi]),
         .in_ready  (cell_ready[gi]),
         .in_data   (cell_data[gi]),
         .out_valid (cell_valid[gi+1]),
         .out_ready (cell_ready[gi+1]),
         .out_data  (cell_data[gi+1])
      );
   end

   assign cell_ready[mafh_pkg::DIV_CELLS] = !rsp_valid_ff || rsp_ready;
   assign load     = cell_valid[mafh_pkg::DIV_CELLS] && cell_ready[mafh_pkg::DIV_CELLS];
   assign fin_info = cell_data[mafh_pkg::DIV_CELLS].info;
   assign sum      = cell_data[mafh_pkg::DIV_CELLS].word +
                     mafh_pkg::FRAME_W'(fin_info.pad);

   always_comb begin
      if (fin_info.zero) begin
         frame_in = '0;
      end else if (fin_info.slot4) begin
         frame_in = {sum[mafh_pkg::FRAME_W-3:0], 2'b00};
      end else begin
         frame_in = sum;
      end
   end

   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         status_ff  <= fin_info.status;
         version_ff <= fin_info.version;
         layer_ff   <= fin_info.layer;
         crc_ff     <= fin_info.crc;
         kbps_ff    <= fin_info.kbps;
         rate_ff    <= fin_info.rate;
         pad_ff     <= fin_info.pad;
         mode_ff    <= fin_info.mode;
         frame_ff   <= frame_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_audio_version  = version_ff;
   assign rsp_layer_number   = layer_ff;
   assign rsp_crc_protected  = crc_ff;
   assign rsp_bitrate_kbps   = kbps_ff;
   assign rsp_sample_rate_hz = rate_ff;
   assign rsp_padding_on     = pad_ff;
   assign rsp_channel_mode   = mode_ff;
   assign rsp_frame_bytes    = frame_ff;

   a_err_zero_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff != mafh_pkg::STATUS_OK |->
         frame_ff == '0 && version_ff == '0 && layer_ff == '0 && kbps_ff == '0)
      else $error("error item carries nonzero fields");

   a_ok_frame_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == mafh_pkg::STATUS_OK && kbps_ff != '0 &&
         rate_ff != '0 |-> frame_ff != '0 && layer_ff != '0)
      else $error("valid header gave zero frame length");

   a_ok_bad_rate_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (kbps_ff == '0 || rate_ff == '0) |-> frame_ff == '0)
      else $error("frame length nonzero with zero bitrate or rate");

endmodule
